// ----- hdl/pfs_pkg.sv -----
package pfs_pkg;

	localparam int BYTES_PER_PANEL = 100;
	localparam int PANEL_COLS      = 29;
	localparam int SCREEN_ROWS     = 24;
	localparam int HALF_ROWS       = 12;

	// chain bit position: signed, wide enough for offset*4 plus a full mirrored row
	localparam int PW  = 15;
	localparam int PBW = PW - 3;

	// x/29 ~ (x*565)>>14 and x/3 ~ (x*171)>>9, exact for x < 256
	localparam logic [9:0] RECIP_29 = 10'd565;
	localparam int         SHR_29   = 14;
	localparam logic [7:0] RECIP_3  = 8'd171;
	localparam int         SHR_3    = 9;

	localparam logic [7:0] PAT_HEAD = 8'hFC;
	localparam logic [7:0] PAT_MID  = 8'hFF;
	localparam logic [7:0] PAT_TAIL = 8'h3F;

	localparam logic REG_PANELS = 1'b0;
	localparam logic REG_OFFSET = 1'b1;

	typedef enum logic [1:0] {
		OP_DRAW  = 2'd0,
		OP_FILL  = 2'd1,
		OP_SHIFT = 2'd2
	} op_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MAP1,
		ST_MAP2,
		ST_DRD,
		ST_DWR,
		ST_FILL,
		ST_SRD,
		ST_SOUT
	} state_t;

	typedef enum logic [1:0] {
		WS_ZERO,
		WS_PAT,
		WS_PIX
	} wsel_t;

	typedef enum logic [1:0] {
		AS_CNT,
		AS_PIX,
		AS_SHIFT
	} asel_t;

	typedef struct packed {
		logic  take;
		logic  map1;
		logic  map2;
		logic  mem_re;
		logic  mem_we;
		asel_t asel;
		wsel_t wsel;
		logic  cnt_inc;
		logic  out_load;
		logic  shift_step;
	} cmd_t;

	typedef struct packed {
		logic cnt_end_all;
		logic cnt_end_act;
		logic pix_ok;
		logic out_busy;
	} sts_t;

	function automatic logic [7:0] fill_pattern(input logic lit, input logic [2:0] phase);
		logic [7:0] v;
		v = 8'h00;
		if (lit) begin
			if (phase == 3'd0)
				v = PAT_HEAD;
			else if (phase == 3'd4)
				v = PAT_TAIL;
			else
				v = PAT_MID;
		end
		return v;
	endfunction

endpackage

// ----- hdl/pfs_if.sv -----
interface pfs_item_if;
	logic              valid;
	logic              ready;
	logic [1:0]        operation;
	logic signed [8:0] x;
	logic signed [6:0] y;
	logic              color;

	modport source (output valid, operation, x, y, color, input ready);
	modport sink (input valid, operation, x, y, color, output ready);
endinterface

interface pfs_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last;

	modport source (output valid, data_byte, last, input ready);
	modport sink (input valid, data_byte, last, output ready);
endinterface

// ----- hdl/pfs_map.sv -----
module pfs_map import pfs_pkg::*; #(
	parameter int NW = 9
) (
	input  logic              clk,
	input  logic              en1,
	input  logic              en2,
	input  logic signed [8:0] x,
	input  logic signed [6:0] y,
	input  logic [2:0]        panels,
	input  logic [9:0]        offset,
	input  logic [NW-1:0]     n_bytes,
	output logic [PBW-1:0]    byte_idx,
	output logic [2:0]        bit_idx,
	output logic              ok
);

	// stage 1: screen check, column quotients, row offset inside a column
	logic [8:0]  width;
	logic [7:0]  xu, xm;
	logic [17:0] p29;
	logic [15:0] p3, pm3;
	logic [4:0]  yl;
	logic [3:0]  row;
	logic        on, upper;

	assign width = 9'(panels) * 9'(PANEL_COLS);
	assign xu    = x[7:0];
	assign yl    = y[4:0];
	assign on    = !x[8] && !y[6] && ({1'b0, xu} < width) && (y[5:0] < 6'(SCREEN_ROWS));
	assign xm    = 8'(width - {1'b0, xu} - 9'd1);
	assign upper = (yl < 5'(HALF_ROWS));
	assign p29   = 18'(xu) * 18'(RECIP_29);
	assign p3    = 16'(xu) * 16'(RECIP_3);
	assign pm3   = 16'(xm) * 16'(RECIP_3);

	always_comb begin
		if (yl < 5'd6)
			row = 4'(yl + 5'd6);
		else if (yl < 5'd12)
			row = 4'(5'd11 - yl);
		else if (yl < 5'd18)
			row = 4'(yl - 5'd12);
		else
			row = 4'(5'd29 - yl);
	end

	logic       on_s1, upper_s1;
	logic [7:0] xu_s1, xm_s1;
	logic [3:0] q29_s1, row_s1;
	logic [6:0] q3_s1, qm3_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			on_s1    <= on;
			upper_s1 <= upper;
			xu_s1    <= xu;
			xm_s1    <= xm;
			q29_s1   <= p29[SHR_29+3:SHR_29];
			q3_s1    <= p3[SHR_3+6:SHR_3];
			qm3_s1   <= pm3[SHR_3+6:SHR_3];
			row_s1   <= row;
		end
	end

	// stage 2: bit position in the chain, then range check
	logic signed [PW-1:0] col, base, pos;
	logic [6:0]           grp;
	logic                 in_store;

	always_comb begin
		if (upper_s1) begin
			col  = PW'(xu_s1) + PW'(q29_s1);
			grp  = q3_s1;
			base = PW'(2);
		end else begin
			col  = PW'(xm_s1) - PW'(q29_s1);
			grp  = qm3_s1;
			base = PW'(2) + (PW'(offset) <<< 2);
		end
		pos = base + (col <<< 3) + (col <<< 2) + (PW'(grp) <<< 2) + PW'(row_s1);
	end

	assign in_store = !pos[PW-1] && (pos[PW-1:3] < PBW'(n_bytes));

	logic [PW-1:0] pos_s2;
	logic          ok_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			pos_s2 <= pos;
			ok_s2  <= on_s1 && in_store;
		end
	end

	assign byte_idx = pos_s2[PW-1:3];
	assign bit_idx  = pos_s2[2:0];
	assign ok       = ok_s2;

endmodule

// ----- hdl/pfs_dp.sv -----
module pfs_dp import pfs_pkg::*; #(
	parameter int MAX_PANELS = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic signed [8:0] x,
	input  logic signed [6:0] y,
	input  logic              color,
	input  logic [2:0]        panels,
	input  logic [9:0]        offset,
	input  logic              shift_rst,
	pfs_result_if.source      result
);

	localparam int DEPTH = MAX_PANELS * BYTES_PER_PANEL;
	localparam int AW    = $clog2(DEPTH);
	localparam int NW    = $clog2(DEPTH + 1);

	logic [NW-1:0] n_bytes;
	logic [AW-1:0] top_idx;

	assign n_bytes = NW'(32'(panels) * 32'(BYTES_PER_PANEL));
	assign top_idx = AW'(n_bytes - NW'(1));

	// captured item
	logic signed [8:0] x_q;
	logic signed [6:0] y_q;
	logic              color_q;

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			x_q     <= x;
			y_q     <= y;
			color_q <= color;
		end
	end

	logic [PBW-1:0] pix_byte;
	logic [2:0]     pix_bit;
	logic           pix_ok;

	pfs_map #(.NW(NW)) u_map (
		.clk      (clk),
		.en1      (cmd.map1),
		.en2      (cmd.map2),
		.x        (x_q),
		.y        (y_q),
		.panels   (panels),
		.offset   (offset),
		.n_bytes  (n_bytes),
		.byte_idx (pix_byte),
		.bit_idx  (pix_bit),
		.ok       (pix_ok)
	);

	// sweep counter for clear and fill, with its position in the 5-byte pattern
	logic [AW-1:0] cnt_q;
	logic [2:0]    phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			phase_q <= '0;
		end else if (cmd.take) begin
			cnt_q   <= '0;
			phase_q <= '0;
		end else if (cmd.cnt_inc) begin
			cnt_q   <= cnt_q + AW'(1);
			phase_q <= (phase_q == 3'd4) ? 3'd0 : phase_q + 3'd1;
		end
	end

	// shift-out index, saturated to the active store
	logic [AW-1:0] shift_q, shift_sat;

	assign shift_sat = (NW'(shift_q) >= n_bytes) ? top_idx : shift_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			shift_q <= AW'(BYTES_PER_PANEL - 1);
		else if (shift_rst)
			shift_q <= top_idx;
		else if (cmd.shift_step)
			shift_q <= (shift_sat == '0) ? top_idx : shift_sat - AW'(1);
	end

	// frame memory
	logic [7:0]    mem_q [DEPTH];
	logic [7:0]    rdata_q;
	logic [AW-1:0] addr;
	logic [7:0]    wdata, bit_mask;

	always_comb begin
		unique case (cmd.asel)
			AS_PIX:   addr = pix_byte[AW-1:0];
			AS_SHIFT: addr = shift_sat;
			default:  addr = cnt_q;
		endcase
	end

	assign bit_mask = 8'd1 << pix_bit;

	always_comb begin
		unique case (cmd.wsel)
			WS_PAT:  wdata = fill_pattern(color_q, phase_q);
			WS_PIX:  wdata = color_q ? (rdata_q | bit_mask) : (rdata_q & ~bit_mask);
			default: wdata = 8'h00;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_we)
			mem_q[addr] <= wdata;
		if (cmd.mem_re)
			rdata_q <= mem_q[addr];
	end

	// result register
	logic       out_valid_q;
	logic [7:0] out_data_q;
	logic       out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q <= rdata_q;
			out_last_q <= (shift_sat == '0);
		end
	end

	assign result.valid     = out_valid_q;
	assign result.data_byte = out_data_q;
	assign result.last      = out_last_q;

	assign sts.cnt_end_all = (cnt_q == AW'(DEPTH - 1));
	assign sts.cnt_end_act = (cnt_q == top_idx);
	assign sts.pix_ok      = pix_ok;
	assign sts.out_busy    = out_valid_q && !result.ready;

endmodule

// ----- hdl/pfs_ctrl.sv -----
module pfs_ctrl import pfs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	pfs_item_if.sink   item,
	input  sts_t       sts,
	output cmd_t       cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLEAR;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.asel   = AS_CNT;
		cmd.wsel   = WS_ZERO;
		item.ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.mem_we = 1'b1;
				if (sts.cnt_end_all)
					state_d = ST_IDLE;
				else
					cmd.cnt_inc = 1'b1;
			end
			ST_IDLE: begin
				item.ready = 1'b1;
				if (item.valid) begin
					cmd.take = 1'b1;
					unique case (op_t'(item.operation))
						OP_DRAW:  state_d = ST_MAP1;
						OP_FILL:  state_d = ST_FILL;
						OP_SHIFT: state_d = ST_SRD;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_MAP1: begin
				cmd.map1 = 1'b1;
				state_d  = ST_MAP2;
			end
			ST_MAP2: begin
				cmd.map2 = 1'b1;
				state_d  = ST_DRD;
			end
			ST_DRD: begin
				if (sts.pix_ok) begin
					cmd.mem_re = 1'b1;
					cmd.asel   = AS_PIX;
					state_d    = ST_DWR;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_DWR: begin
				cmd.mem_we = 1'b1;
				cmd.asel   = AS_PIX;
				cmd.wsel   = WS_PIX;
				state_d    = ST_IDLE;
			end
			ST_FILL: begin
				cmd.mem_we = 1'b1;
				cmd.wsel   = WS_PAT;
				if (sts.cnt_end_act)
					state_d = ST_IDLE;
				else
					cmd.cnt_inc = 1'b1;
			end
			ST_SRD: begin
				cmd.mem_re = 1'b1;
				cmd.asel   = AS_SHIFT;
				state_d    = ST_SOUT;
			end
			ST_SOUT: begin
				if (!sts.out_busy) begin
					cmd.out_load   = 1'b1;
					cmd.shift_step = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ----- hdl/panel_pixel_frame_store.sv -----
// Draw: two map stages, then a read and a write of one byte on the single memory port;
//   a pixel that falls off the store skips the read and the write and goes back to ready.
// Fill: covers the active bytes, one byte per cycle through the memory write port.
// Shift: a read, then any wait for the result register to drain; unused op: back to idle.
// Reset (arst_n low, async): registers to defaults, then a clearing pass zeroes all
//   MAX_PANELS*100 bytes of the store; no transaction is taken until it ends.
module panel_pixel_frame_store import pfs_pkg::*; #(
	parameter int MAX_PANELS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	pfs_item_if.sink    item,
	pfs_result_if.source result
);

	// ---------------------------------------------------------------
	// Configuration registers (APB, zero wait states)
	//   0x0 panel_count       raw 3-bit value, clamped to 1..MAX_PANELS on use
	//   0x4 lower_half_offset start of the mirrored rows, in nibbles
	// Only paddr[2] decodes the register.
	// ---------------------------------------------------------------
	logic [2:0] panels_raw_q;
	logic [9:0] offset_q;
	logic       shift_rst_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			panels_raw_q <= 3'd1;
			offset_q     <= 10'd100;
			shift_rst_q  <= 1'b0;
		end else begin
			shift_rst_q <= 1'b0;
			if (cfg_wr) begin
				unique case (paddr[2])
					REG_PANELS: begin
						panels_raw_q <= pwdata[2:0];
						// reload the shift index once the new count is in place
						shift_rst_q  <= 1'b1;
					end
					default: offset_q <= pwdata[9:0];
				endcase
			end
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_PANELS: prdata = 32'(panels_raw_q);
			default:    prdata = 32'(offset_q);
		endcase
	end

	// effective panel count: zero acts as one, anything past the build limit saturates
	logic [2:0] panels;

	always_comb begin
		if (panels_raw_q == 3'd0)
			panels = 3'd1;
		else if (32'(panels_raw_q) > MAX_PANELS)
			panels = 3'(MAX_PANELS);
		else
			panels = panels_raw_q;
	end

	// ---------------------------------------------------------------
	// Controller and datapath
	// ---------------------------------------------------------------
	cmd_t cmd;
	sts_t sts;

	pfs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.sts    (sts),
		.cmd    (cmd)
	);

	pfs_dp #(.MAX_PANELS(MAX_PANELS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.x         (item.x),
		.y         (item.y),
		.color     (item.color),
		.panels    (panels),
		.offset    (offset_q),
		.shift_rst (shift_rst_q),
		.result    (result)
	);

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
	// a pixel write only happens for a position inside the active store
	a_pix_write_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mem_we && (cmd.wsel == WS_PIX) |-> sts.pix_ok)
		else $error("pixel write with out-of-store position");

	// a result is never loaded over one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !sts.out_busy)
		else $error("result register overwritten");

	// every new result comes from a shift transaction
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(cmd.out_load))
		else $error("result valid without a load");

	// the memory port is quiet while a transaction is taken
	a_accept_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |-> !cmd.mem_we && !cmd.mem_re)
		else $error("memory busy at transaction accept");

endmodule
